// File: rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants for the line rasterizer: field widths, register
// map, controller states and the command and status groups between modules.
// ----------------------------------------------------------------------------
package brl_pkg;

   localparam int COORD_BITS = 6;
   localparam int FIELD_BITS = 6;
   localparam int COLOR_BITS = 8;
   localparam int ROWS_BITS  = 7;
   localparam int ERR_BITS   = COORD_BITS + 3;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] REG_SCREEN_ROWS = 2'd0;
   localparam logic [ROWS_BITS-1:0]     SCREEN_ROWS_RESET = 7'd64;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_END,
      ST_WALK
   } state_type;

   typedef struct packed {
      coord_type              start_x;
      coord_type              start_y;
      coord_type              end_x;
      coord_type              end_y;
      logic [COLOR_BITS-1:0]  color;
   } line_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0]  x;
      logic [FIELD_BITS-1:0]  y;
      logic [COLOR_BITS-1:0]  color;
      logic                   visible;
      logic                   last;
   } pixel_type;

   typedef struct packed {
      logic load;
      logic step;
      logic sel_end;
   } cmd_type;

   typedef struct packed {
      logic is_last;
   } status_type;

endpackage

// File: rtl/brl_ctrl.sv
// ----------------------------------------------------------------------------
// brl_ctrl
// Controller for the line rasterizer: takes a command, presents the end pixel,
// then steps the walk one pixel per accepted beat until the last one.
// ----------------------------------------------------------------------------
module brl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  brl_pkg::status_type status,
   output brl_pkg::cmd_type    cmd
);
   import brl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            if (rsp_tready) begin
               state_in = status.is_last ? ST_IDLE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (rsp_tready && status.is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.sel_end = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_END: begin
            rsp_tvalid  = 1'b1;
            cmd.sel_end = 1'b1;
         end
         ST_WALK: begin
            rsp_tvalid = 1'b1;
            cmd.step   = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/brl_datapath.sv
// ----------------------------------------------------------------------------
// brl_datapath
// Line walk datapath: holds the current point, the end point, the deltas,
// step directions and the error term, and forms the pixel being presented.
// ----------------------------------------------------------------------------
module brl_datapath (
   input  logic                          clock,
   input  brl_pkg::cmd_type              cmd,
   input  brl_pkg::line_type             line,
   input  logic [brl_pkg::ROWS_BITS-1:0] screen_rows,
   output brl_pkg::pixel_type            pixel,
   output brl_pkg::status_type           status
);
   import brl_pkg::*;

   coord_type             x_ff, y_ff, ex_ff, ey_ff, dx_ff, dy_ff;
   coord_type             x_in, y_in, ex_in, ey_in, dx_in, dy_in;
   logic                  sx_ff, sy_ff, sx_in, sy_in;
   err_type               err_ff, err_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   err_type   e2, dx_s, dy_s, err_next;
   logic      step_x, step_y;
   coord_type x_next, y_next, out_x, out_y;
   coord_type load_dx, load_dy;

   always_comb begin
      load_dx = (line.end_x > line.start_x) ? line.end_x - line.start_x
                                            : line.start_x - line.end_x;
      load_dy = (line.end_y > line.start_y) ? line.end_y - line.start_y
                                            : line.start_y - line.end_y;
   end

   always_comb begin
      dx_s     = $signed(ERR_BITS'(dx_ff));
      dy_s     = $signed(ERR_BITS'(dy_ff));
      e2       = err_ff <<< 1;
      step_x   = e2 > -dy_s;
      step_y   = e2 < dx_s;
      err_next = err_ff - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
      x_next   = step_x ? (sx_ff ? x_ff + 1'b1 : x_ff - 1'b1) : x_ff;
      y_next   = step_y ? (sy_ff ? y_ff + 1'b1 : y_ff - 1'b1) : y_ff;
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      err_in   = err_ff;
      color_in = color_ff;
      if (cmd.load) begin
         x_in     = line.start_x;
         y_in     = line.start_y;
         ex_in    = line.end_x;
         ey_in    = line.end_y;
         dx_in    = load_dx;
         dy_in    = load_dy;
         sx_in    = line.start_x < line.end_x;
         sy_in    = line.start_y < line.end_y;
         err_in   = $signed(ERR_BITS'(load_dx)) - $signed(ERR_BITS'(load_dy));
         color_in = line.color;
      end else if (cmd.step) begin
         x_in   = x_next;
         y_in   = y_next;
         err_in = err_next;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      err_ff   <= err_in;
      color_ff <= color_in;
   end

   always_comb begin
      out_x = cmd.sel_end ? ex_ff : x_ff;
      out_y = cmd.sel_end ? ey_ff : y_ff;
      if (cmd.sel_end) begin
         status.is_last = (x_ff == ex_ff) && (y_ff == ey_ff);
      end else begin
         status.is_last = (x_next == ex_ff) && (y_next == ey_ff);
      end
      pixel.x       = FIELD_BITS'(out_x);
      pixel.y       = FIELD_BITS'(out_y);
      pixel.color   = color_ff;
      pixel.visible = ROWS_BITS'(out_y) < screen_rows;
      pixel.last    = status.is_last;
   end

endmodule

// File: rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer-error line rasterizer with a streaming command input, a streaming
// pixel output and a register port for the display row count.
// ----------------------------------------------------------------------------
// A line command is taken only while the block is idle. The cycle after it is
// taken the end pixel is presented, then the walk from the start pixel follows
// at one pixel per accepted beat, so a command with deltas dx and dy occupies
// max(dx, dy) + 1 output beats. The output fields are held while the pixel beat
// is stalled.
module bresenham_line_rasterizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], draw_color[31:24]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_x[5:0], pixel_y[11:6], pixel_color[19:12], visible[20], zero[23:21]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [brl_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [brl_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [brl_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic        csr_pready
);
   import brl_pkg::*;

   logic [ROWS_BITS-1:0] screen_rows_ff, screen_rows_in;
   line_type             line;
   pixel_type            pixel;
   cmd_type              cmd;
   status_type           status;
   logic                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      screen_rows_in = screen_rows_ff;
      if (csr_write && (csr_paddr == REG_SCREEN_ROWS)) begin
         screen_rows_in = csr_pwdata[ROWS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= SCREEN_ROWS_RESET;
      end else begin
         screen_rows_ff <= screen_rows_in;
      end
   end

   assign csr_prdata = (csr_paddr == REG_SCREEN_ROWS) ?
                       CSR_DATA_BITS'(screen_rows_ff) : '0;

   assign line.start_x = req_tdata[COORD_BITS-1:0];
   assign line.start_y = req_tdata[FIELD_BITS+COORD_BITS-1:FIELD_BITS];
   assign line.end_x   = req_tdata[2*FIELD_BITS+COORD_BITS-1:2*FIELD_BITS];
   assign line.end_y   = req_tdata[3*FIELD_BITS+COORD_BITS-1:3*FIELD_BITS];
   assign line.color   = req_tdata[4*FIELD_BITS+COLOR_BITS-1:4*FIELD_BITS];

   brl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   brl_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .line        (line),
      .screen_rows (screen_rows_ff),
      .pixel       (pixel),
      .status      (status)
   );

   assign rsp_tdata = {3'b000, pixel.visible, pixel.color, pixel.y, pixel.x};
   assign rsp_tlast = pixel.last;

   // The block never takes a command while a pixel beat is pending.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("command accepted while pixels pending");

   // The first pixel of a command is its end point.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=>
         (rsp_tvalid && (rsp_tdata[11:0] == $past(req_tdata[23:12]))))
      else $error("first pixel is not the end point");

   // Once the last pixel is taken the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after last pixel");

   // Pixels keep flowing until the last one is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("pixel stream ended without last");

endmodule

// File: tb/sv/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer
// Self-checking bench for the line rasterizer. Line commands come from a queue
// and are driven with random gaps. The bench computes the expected pixels of
// each accepted command with its own integer walk and compares every pixel
// beat field by field. The row count register is changed between phases while
// the block is idle, and it covers zero, one, 64 and the largest code.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer;

   import brl_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 100;
   localparam int MAX_PIXELS  = 1 << COORD_BITS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   line_type  line_queue[$];
   pixel_type pixel_queue[$];
   int        rows_model = SCREEN_ROWS_RESET;
   int        error_count = 0;
   int        send_gap = 0;
   int        ready_stall = 0;
   int        idle_cycles = 0;
   bit        calm = 1'b0;

   bresenham_line_rasterizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic void add_line(input line_type cmd);
      line_queue.insert(line_queue.size(), cmd);
   endfunction

   function automatic void add_pixel(input pixel_type pix);
      pixel_queue.insert(pixel_queue.size(), pix);
   endfunction

   function automatic pixel_type make_pixel(input int px, input int py, input logic [7:0] color);
      pixel_type pix;
      pix.x = px[FIELD_BITS-1:0];
      pix.y = py[FIELD_BITS-1:0];
      pix.color = color;
      pix.visible = (py < rows_model);
      pix.last = 1'b0;
      return pix;
   endfunction

   // End pixel first, then the walk from the start point up to but not
   // including the end pixel. The final pixel carries the last flag.
   function automatic void rasterize(input line_type cmd);
      int cx, cy, ex, ey, dx, dy, sx, sy, err, e2, count;
      pixel_type held;
      cx = cmd.start_x;
      cy = cmd.start_y;
      ex = cmd.end_x;
      ey = cmd.end_y;
      dx = (ex > cx) ? ex - cx : cx - ex;
      dy = (ey > cy) ? ey - cy : cy - ey;
      sx = (cx < ex) ? 1 : -1;
      sy = (cy < ey) ? 1 : -1;
      err = dx - dy;
      held = make_pixel(ex, ey, cmd.color);
      count = 1;
      while ((cx != ex || cy != ey) && count < MAX_PIXELS) begin
         add_pixel(held);
         held = make_pixel(cx, cy, cmd.color);
         count++;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            cx += sx;
         end
         if (e2 < dx) begin
            err += dx;
            cy += sy;
         end
      end
      held.last = 1'b1;
      add_pixel(held);
   endfunction

   function automatic line_type make_line(input int x0, input int y0, input int x1, input int y1,
                                          input int color);
      line_type cmd;
      cmd.start_x = x0[COORD_BITS-1:0];
      cmd.start_y = y0[COORD_BITS-1:0];
      cmd.end_x = x1[COORD_BITS-1:0];
      cmd.end_y = y1[COORD_BITS-1:0];
      cmd.color = color[COLOR_BITS-1:0];
      return cmd;
   endfunction

   function automatic int near_coord(input int base);
      int v;
      v = base + $urandom_range(0, 12) - 6;
      if (v < 0) v = 0;
      if (v > MAX_PIXELS - 1) v = MAX_PIXELS - 1;
      return v;
   endfunction

   function automatic line_type random_line();
      int x0, y0, kind;
      x0 = $urandom_range(0, MAX_PIXELS - 1);
      y0 = $urandom_range(0, MAX_PIXELS - 1);
      kind = $urandom_range(0, 9);
      if (kind < 5)
         return make_line(x0, y0, $urandom_range(0, MAX_PIXELS - 1),
                          $urandom_range(0, MAX_PIXELS - 1), $urandom_range(0, 255));
      else if (kind < 9)
         return make_line(x0, y0, near_coord(x0), near_coord(y0), $urandom_range(0, 255));
      else
         return make_line(x0, y0, x0, y0, $urandom_range(0, 255));
   endfunction

   task automatic wait_drained();
      while (line_queue.size() != 0 || pixel_queue.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_rows(input int rows);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_SCREEN_ROWS;
      csr_pwdata <= rows;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      rows_model = rows & 7'h7F;
      @(negedge clock);
   endtask

   task automatic random_phase(input int rows, input int count);
      wait_drained();
      write_rows(rows);
      repeat (count) add_line(random_line());
   endtask

   // Command driver: a command stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            rasterize(line_queue.pop_front());
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (line_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 6) - 1;
            req_tvalid <= 1'b0;
         end else if (line_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {line_queue[0].color, line_queue[0].end_y, line_queue[0].end_x,
                          line_queue[0].start_y, line_queue[0].start_x};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Pixel monitor and ready stalls.
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch($sformatf("pixel beat with nothing pending, data %h", rsp_tdata));
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_tdata[5:0] !== want.x)
                  report_mismatch($sformatf("pixel_x %0d, want %0d", rsp_tdata[5:0], want.x));
               if (rsp_tdata[11:6] !== want.y)
                  report_mismatch($sformatf("pixel_y %0d, want %0d", rsp_tdata[11:6], want.y));
               if (rsp_tdata[19:12] !== want.color)
                  report_mismatch($sformatf("pixel_color %h, want %h", rsp_tdata[19:12],
                                            want.color));
               if (rsp_tdata[20] !== want.visible)
                  report_mismatch($sformatf("visible %b, want %b at row %0d", rsp_tdata[20],
                                            want.visible, want.y));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %b, want %b at (%0d,%0d)", rsp_tlast,
                                            want.last, want.x, want.y));
            end
         end
         if (ready_stall > 0) begin
            ready_stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            ready_stall = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_bresenham_line_rasterizer: errors");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Row count still at its reset value of 64.
      add_line(make_line(0, 0, 0, 0, 8'h00));
      add_line(make_line(63, 63, 63, 63, 8'hFF));
      add_line(make_line(0, 0, 63, 0, 8'hA5));
      add_line(make_line(63, 5, 0, 5, 8'h5A));
      add_line(make_line(10, 0, 10, 63, 8'h01));
      add_line(make_line(20, 63, 20, 0, 8'h80));
      add_line(make_line(0, 0, 63, 63, 8'h7F));
      add_line(make_line(63, 63, 0, 0, 8'hFE));
      add_line(make_line(63, 0, 0, 63, 8'h33));
      add_line(make_line(0, 63, 63, 0, 8'hCC));
      add_line(make_line(0, 0, 63, 1, 8'h0F));
      add_line(make_line(0, 0, 1, 63, 8'hF0));
      add_line(make_line(5, 60, 40, 3, 8'h69));
      add_line(make_line(40, 3, 5, 60, 8'h96));
      add_line(make_line(31, 32, 32, 31, 8'h55));
      add_line(make_line(62, 62, 63, 63, 8'hAA));

      random_phase(1, 60);
      add_line(make_line(0, 0, 0, 63, 8'h12));
      random_phase(0, 40);
      random_phase(127, 40);
      add_line(make_line(63, 0, 63, 63, 8'h34));
      random_phase(64, 100);
      random_phase($urandom_range(2, 63), 80);

      wait_drained();
      write_rows($urandom_range(1, 64));
      calm = 1'b1;
      repeat (80) add_line(random_line());

      wait_drained();
      repeat (70) @(negedge clock);
      if (error_count == 0)
         $display("tb_bresenham_line_rasterizer: clean");
      else
         $display("tb_bresenham_line_rasterizer: errors");
      $finish;
   end

endmodule
